// ===== hdl/burst_score_task_scheduler_macros.svh =====
// Assertion macros shared by the scheduler top level.
// No dependencies; include after the clock and reset are declared.
`ifndef BURST_SCORE_TASK_SCHEDULER_MACROS_SVH
`define BURST_SCORE_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BSTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is low
`define BSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== hdl/bsts_pkg.sv =====
// Shared types and constants of the burst-score task scheduler.
// No dependencies; compiled before every other file of the block.
package bsts_pkg;

    // Default values of the top-level parameters
    localparam int TASK_SLOTS_DEF = 256;
    localparam int CPU_COUNT_DEF  = 256;
    localparam int TIME_BITS_DEF  = 64;

    // Field and port widths
    localparam int ACT_W      = 3;
    localparam int SCORE_W    = 8;
    localparam int CPU_W      = 8;
    localparam int SLICE_W    = 33;
    localparam int THR_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 56;
    localparam int PROD_W     = SCORE_W + CFG_DATA_W;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INIT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RUN   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ENQ   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEL   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREFER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR    = 3'd4;

    // Configuration reset values
    localparam logic                  PREFER_RST = 1'b1;
    localparam logic [CFG_DATA_W-1:0] BASE_RST   = 32'd5000000;
    localparam logic [CFG_DATA_W-1:0] MIN_RST    = 32'd1000000;
    localparam logic [CFG_DATA_W-1:0] MAX_RST    = 32'd20000000;
    localparam logic [THR_W-1:0]      THR_RST    = 9'd50;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 8'd255;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the input word and read the table
        logic exec;     // update the entry and form the result
        logic div_a;    // first step of the divide by 255
        logic div_b;    // correction and base add
        logic load;     // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_div; // enqueue needs the scaled batch slice
    } t_stat;

endpackage

// ===== hdl/bsts_ctrl.sv =====
// Sequencer of the burst-score task scheduler: accepts words, steps the
// datapath and owns the output valid flag. Depends on bsts_pkg.
module bsts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  bsts_pkg::t_stat i_stat,
    output bsts_pkg::t_cmd  o_cmd
);
    import bsts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_A,
        ST_DIV_B,
        ST_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   load;

    // Finish only when the output register is free or being emptied
    assign load = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    // Decode commands from the state
    always_comb begin
        o_cmd.capture = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == ST_EXEC);
        o_cmd.div_a   = (r_state == ST_DIV_A);
        o_cmd.div_b   = (r_state == ST_DIV_B);
        o_cmd.load    = load;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= i_stat.need_div ? ST_DIV_A : ST_FIN;
                end
                ST_DIV_A: begin
                    r_state <= ST_DIV_B;
                end
                ST_DIV_B: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/bsts_datapath.sv =====
// Datapath of the burst-score task scheduler: configuration registers, task
// table with valid bits, score update, slice divider and output register.
// Depends on bsts_pkg.
module bsts_datapath #(
    parameter int TASK_SLOTS = bsts_pkg::TASK_SLOTS_DEF,
    parameter int CPU_COUNT  = bsts_pkg::CPU_COUNT_DEF,
    parameter int TIME_BITS  = bsts_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bsts_pkg::t_cmd                    i_cmd,
    output bsts_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_wr_en,
    input  logic [bsts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [bsts_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic [bsts_pkg::ACT_W-1:0]        i_in_user,
    output logic [bsts_pkg::OUT_DATA_W-1:0]   o_out_data
);
    import bsts_pkg::*;

    // Only the first 256 slots can be addressed by an 8-bit slot field
    localparam int DEPTH   = (TASK_SLOTS < 256) ? TASK_SLOTS : 256;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int ENTRY_W = SCORE_W + 1 + TIME_BITS;
    localparam logic [8:0] CPU_LIM = (CPU_COUNT > 255) ? 9'd256 : 9'(CPU_COUNT);

    // Slot field reduced to a table index
    logic [SLOT_W-1:0] slot_map [256];
    for (genvar g = 0; g < 256; g++) begin : g_map
        assign slot_map[g] = SLOT_W'(g % DEPTH);
    end

    // Configuration
    logic                  r_cfg_prefer;
    logic [CFG_DATA_W-1:0] r_cfg_base;
    logic [CFG_DATA_W-1:0] r_cfg_min;
    logic [CFG_DATA_W-1:0] r_cfg_max;
    logic [THR_W-1:0]      r_cfg_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_prefer <= PREFER_RST;
            r_cfg_base   <= BASE_RST;
            r_cfg_min    <= MIN_RST;
            r_cfg_max    <= MAX_RST;
            r_cfg_thr    <= THR_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PREFER: r_cfg_prefer <= i_cfg_data[0];
                CFG_BASE:   r_cfg_base   <= i_cfg_data;
                CFG_MIN:    r_cfg_min    <= i_cfg_data;
                CFG_MAX:    r_cfg_max    <= i_cfg_data;
                CFG_THR:    r_cfg_thr    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Input word capture
    logic [SLOT_W-1:0]    in_slot;
    logic [ACT_W-1:0]     r_act;
    logic [SLOT_W-1:0]    r_slot;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_rt_in;
    logic [CPU_W-1:0]     r_prev;
    logic [8:0]           r_idle;
    logic                 r_present;

    assign in_slot = slot_map[i_in_data[7:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act   <= i_in_user;
            r_slot  <= in_slot;
            r_now   <= i_in_data[8 +: TIME_BITS];
            r_rt_in <= i_in_data[72];
            r_prev  <= i_in_data[80:73];
            r_idle  <= i_in_data[89:81];
        end
    end

    // Valid bits, cleared at reset
    logic [DEPTH-1:0] r_valid;
    logic             valid_after;
    logic             wr_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.exec && valid_after) begin
            r_valid[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_present <= r_valid[in_slot];
        end
    end

    // Task table: {score, realtime, start time}
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd;
    logic [ENTRY_W-1:0] new_entry;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd <= mem[in_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_entry) begin
            mem[r_slot] <= new_entry;
        end
    end

    // Entry update
    logic [SCORE_W-1:0]   cur_score;
    logic                 cur_rt;
    logic [TIME_BITS-1:0] cur_time;
    logic [TIME_BITS-1:0] run_len;
    logic                 long_run;
    logic [SCORE_W-1:0]   new_score;
    logic                 new_rt;
    logic [TIME_BITS-1:0] new_time;
    logic                 new_inter;
    logic                 idle_ok;
    logic                 is_enq;
    logic                 is_sel;
    logic [CPU_W-1:0]     cpu_sel;
    logic [SLICE_W-1:0]   slice_fast;

    always_comb begin
        cur_score = r_present ? r_rd[ENTRY_W-1 -: SCORE_W] : '0;
        cur_rt    = r_present ? r_rd[TIME_BITS] : 1'b0;
        cur_time  = r_present ? r_rd[TIME_BITS-1:0] : '0;
        run_len   = r_now - cur_time;
        long_run  = run_len > TIME_BITS'(r_cfg_base);

        new_score   = cur_score;
        new_rt      = cur_rt;
        new_time    = cur_time;
        wr_entry    = 1'b0;
        valid_after = r_present;

        unique case (r_act)
            ACT_INIT: begin
                new_score   = '0;
                new_rt      = r_rt_in;
                new_time    = r_now;
                wr_entry    = 1'b1;
                valid_after = 1'b1;
            end
            ACT_RUN: begin
                new_time = r_now;
                wr_entry = r_present;
            end
            ACT_STOP: begin
                wr_entry = r_present;
                if (long_run) begin
                    if (cur_score != SCORE_MAX) begin
                        new_score = cur_score + 8'd1;
                    end
                end else if (cur_score != '0) begin
                    new_score = cur_score - 8'd1;
                end
            end
            ACT_ENQ: begin
                // missing entry: create it zeroed (cur_* already zero)
                wr_entry    = !r_present;
                valid_after = 1'b1;
            end
            default: ;
        endcase

        new_entry = {new_score, new_rt, new_time};
        new_inter = {1'b0, new_score} < r_cfg_thr;
        idle_ok   = !r_idle[8] && ({1'b0, r_idle[7:0]} < CPU_LIM);
        is_enq    = (r_act == ACT_ENQ);
        is_sel    = (r_act == ACT_SEL);

        if (is_sel && r_present && !cur_rt && r_cfg_prefer && new_inter && idle_ok) begin
            cpu_sel = r_idle[7:0];
        end else if (is_sel) begin
            cpu_sel = r_prev;
        end else begin
            cpu_sel = '0;
        end

        if (!is_enq) begin
            slice_fast = '0;
        end else if (new_rt) begin
            slice_fast = {1'b0, r_cfg_min};
        end else begin
            slice_fast = {r_cfg_min, 1'b0};
        end

        o_stat.need_div = is_enq && !new_rt && !new_inter;
    end

    // Result of the step
    logic [CPU_W-1:0]   r_res_cpu;
    logic               r_res_local;
    logic [SCORE_W-1:0] r_res_score;
    logic               r_res_inter;
    logic               r_res_present;
    logic               r_res_div;
    logic [SLICE_W-1:0] r_res_fast;
    logic [PROD_W-1:0]  r_prod;

    // Enqueue leaves the score as read, so the product starts from the stored score
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_cpu     <= cpu_sel;
            r_res_local   <= is_enq && (new_inter || new_rt);
            r_res_score   <= valid_after ? new_score : '0;
            r_res_inter   <= valid_after && new_inter;
            r_res_present <= r_present;
            r_res_div     <= o_stat.need_div;
            r_res_fast    <= slice_fast;
            r_prod        <= PROD_W'(cur_score) * PROD_W'(r_cfg_base);
        end
    end

    // Divide score*base by 255: digit-sum estimate, then small correction
    logic [CFG_DATA_W-1:0] r_q0;
    logic [10:0]           q0_x255;
    logic [10:0]           rem0;
    logic [2:0]            q_fix;
    logic [SLICE_W-1:0]    r_sum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_a) begin
            r_q0 <= r_prod[39:8] + {8'd0, r_prod[39:16]}
                  + {16'd0, r_prod[39:24]} + {24'd0, r_prod[39:32]};
        end
    end

    always_comb begin
        // low bits only: the true remainder stays below 2048
        q0_x255 = {r_q0[2:0], 8'd0} - r_q0[10:0];
        rem0    = r_prod[10:0] - q0_x255;
        q_fix   = 3'(rem0 >= 11'd255) + 3'(rem0 >= 11'd510) + 3'(rem0 >= 11'd765)
                + 3'(rem0 >= 11'd1020) + 3'(rem0 >= 11'd1275);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_b) begin
            r_sum <= {1'b0, r_cfg_base} + {1'b0, r_q0} + SLICE_W'(q_fix);
        end
    end

    // Output register
    logic [SLICE_W-1:0] slice_final;
    logic [CPU_W-1:0]   r_out_cpu;
    logic               r_out_local;
    logic [SLICE_W-1:0] r_out_slice;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_inter;
    logic               r_out_present;

    always_comb begin
        if (!r_res_div) begin
            slice_final = r_res_fast;
        end else if (r_sum > {1'b0, r_cfg_max}) begin
            slice_final = {1'b0, r_cfg_max};
        end else begin
            slice_final = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_cpu     <= r_res_cpu;
            r_out_local   <= r_res_local;
            r_out_slice   <= slice_final;
            r_out_score   <= r_res_score;
            r_out_inter   <= r_res_inter;
            r_out_present <= r_res_present;
        end
    end

    assign o_out_data = {4'd0, r_out_present, r_out_inter, r_out_score,
                         r_out_slice, r_out_local, r_out_cpu};

endmodule

// ===== hdl/burst_score_task_scheduler.sv =====
// Burst-score task scheduler. An accepted word steps through execute and, for
// an enqueue that takes the scaled batch slice, the two-stage divide by 255 of
// the slice scaler, then waits to load the output register; no new word is taken
// until that load, so the table read-modify-write never overlaps the next word.
// Reset (synchronous, active low): all slot valid bits clear at once, no
// clearing pass; configuration registers return to their defaults.
module burst_score_task_scheduler #(
    parameter int TASK_SLOTS = bsts_pkg::TASK_SLOTS_DEF,
    parameter int CPU_COUNT  = bsts_pkg::CPU_COUNT_DEF,
    parameter int TIME_BITS  = bsts_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [bsts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // task_slot[7:0], now_ns[71:8], is_realtime[72], last_cpu[80:73],
    // idle_cpu[89:81], zero[95:90]
    input  logic [bsts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [bsts_pkg::ACT_W-1:0]      s_axis_tuser,
    // result words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cpu_choice[7:0], to_local_queue[8], slice_out[41:9], score_out[49:42],
    // interactive[50], entry_present[51], zero[55:52]
    output logic [bsts_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bsts_pkg::*;

`include "burst_score_task_scheduler_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    bsts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bsts_datapath #(
        .TASK_SLOTS (TASK_SLOTS),
        .CPU_COUNT  (CPU_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

    // A result never overwrites a word still waiting downstream
    `BSTS_ASSERT_NOW(a_load_free, i_clk, i_rst_n, cmd.load, !m_axis_tvalid || m_axis_tready)
    // An accepted word is executed in the next cycle
    `BSTS_ASSERT_NEXT(a_capture_exec, i_clk, i_rst_n, cmd.capture, cmd.exec && !s_axis_tready)
    // A scaled slice always runs the divider
    `BSTS_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, cmd.exec && stat.need_div, cmd.div_a)

endmodule
